### rtl/owq_pkg.sv
package owq_pkg;

  // operation codes on the input channel
  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // per-transfer control broadcast to every cell
  typedef struct packed {
    logic do_put;
    logic do_take;
  } cell_ctl_t;

endpackage

### rtl/owq_in_if.sv
interface owq_in_if #(
  parameter int ID_W = 8
);
  logic            valid;
  logic            ready;
  logic [1:0]      operation;
  logic [ID_W-1:0] task_id;

  modport source (output valid, output operation, output task_id, input ready);
  modport sink   (input valid, input operation, input task_id, output ready);
endinterface

### rtl/owq_out_if.sv
interface owq_out_if #(
  parameter int ID_W  = 8,
  parameter int CNT_W = 5
);
  logic             valid;
  logic             ready;
  owq_pkg::status_t status;
  logic [ID_W-1:0]  out_task_id;
  logic [CNT_W-1:0] occupancy;

  modport source (output valid, output status, output out_task_id, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input out_task_id, input occupancy,
                  output ready);
endinterface

### rtl/owq_cell.sv
module owq_cell #(
  parameter int ID_W = 8,
  parameter bit HEAD = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  owq_pkg::cell_ctl_t ctl_i,
  input  logic               pop_i,
  input  logic [ID_W-1:0]    key_i,
  input  logic               prev_valid_i,
  input  logic               prev_hit_i,
  input  logic [ID_W-1:0]    prev_got_i,
  input  logic               next_valid_i,
  input  logic [ID_W-1:0]    next_id_i,
  output logic               valid_o,
  output logic [ID_W-1:0]    id_o,
  output logic               match_o,
  output logic               hit_o,
  output logic [ID_W-1:0]    got_o
);

  logic            valid_r, valid_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic            tail;

  // pop selects the head cell, put and remove compare the key
  assign match_o = valid_r && (pop_i ? HEAD : (id_r == key_i));
  assign hit_o   = prev_hit_i | match_o;
  assign got_o   = prev_got_i | (match_o ? id_r : '0);
  assign tail    = prev_valid_i && !valid_r;
  assign valid_o = valid_r;
  assign id_o    = id_r;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    if (ctl_i.do_take && hit_o) begin
      // close the gap: take the neighbor's entry
      valid_nxt = next_valid_i;
      id_nxt    = next_id_i;
    end else if (ctl_i.do_put && tail) begin
      valid_nxt = 1'b1;
      id_nxt    = key_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

### rtl/ordered_wait_queue_with_cancel.sv
// a result is registered and shown in the cycle after the input transfer
// throughput: one item per cycle while each result is taken in the cycle it shows;
//   the cell row compares, shifts and appends on the input transfer itself, and a result
//   that waits holds in_req.ready low until the result transfer
// reset: synchronous active-low rst_n empties the queue (cell valid bits, count)
//   and drops any pending result; held identifiers are not cleared
module ordered_wait_queue_with_cancel #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  owq_in_if.sink     in_req,
  owq_out_if.source  out_res
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // cell row wiring
  logic [QUEUE_DEPTH-1:0] valid_vec;
  logic [QUEUE_DEPTH-1:0] match_vec;
  logic [QUEUE_DEPTH-1:0] prev_valid;
  logic [QUEUE_DEPTH-1:0] next_valid;
  logic [ID_BITS-1:0]     id_arr   [QUEUE_DEPTH];
  logic [ID_BITS-1:0]     next_id  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   hit_c;                  // prefix of matches along the row
  logic [ID_BITS-1:0]     got_c    [QUEUE_DEPTH+1]; // removed identifier along the row

  owq_pkg::cell_ctl_t ctl;
  logic               is_pop;
  logic               accept;
  logic               in_ready;
  logic               any_hit;
  logic               full;
  owq_pkg::status_t   st;
  logic [ID_BITS-1:0] got;
  logic [CNT_W-1:0]   cnt_after;

  logic               out_valid_r;
  owq_pkg::status_t   status_r;
  logic [ID_BITS-1:0] out_id_r;
  logic [CNT_W-1:0]   occ_r;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // a new item may enter when the result register is empty or being drained
  assign in_ready     = !out_valid_r || out_res.ready;
  assign in_req.ready = in_ready;
  assign accept       = in_req.valid && in_ready;
  assign is_pop       = (in_req.operation == owq_pkg::OP_POP);

  assign hit_c[0] = 1'b0;
  assign got_c[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      // head cell sees an always-valid predecessor so it can take the first put
      if (gi == 0) begin : g_head
        assign prev_valid[gi] = 1'b1;
      end else begin : g_body
        assign prev_valid[gi] = valid_vec[gi-1];
      end
      // last cell shifts in an empty slot
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign next_valid[gi] = 1'b0;
        assign next_id[gi]    = '0;
      end else begin : g_inner
        assign next_valid[gi] = valid_vec[gi+1];
        assign next_id[gi]    = id_arr[gi+1];
      end

      owq_cell #(
        .ID_W (ID_BITS),
        .HEAD (gi == 0)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_i        (ctl),
        .pop_i        (is_pop),
        .key_i        (in_req.task_id),
        .prev_valid_i (prev_valid[gi]),
        .prev_hit_i   (hit_c[gi]),
        .prev_got_i   (got_c[gi]),
        .next_valid_i (next_valid[gi]),
        .next_id_i    (next_id[gi]),
        .valid_o      (valid_vec[gi]),
        .id_o         (id_arr[gi]),
        .match_o      (match_vec[gi]),
        .hit_o        (hit_c[gi+1]),
        .got_o        (got_c[gi+1])
      );
    end
  endgenerate

  assign any_hit = hit_c[QUEUE_DEPTH];
  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));

  // decode the operation into status, removed id, new count and cell control
  always_comb begin
    st          = owq_pkg::ST_NONE;
    got         = '0;
    cnt_after   = count_r;
    ctl.do_put  = 1'b0;
    ctl.do_take = 1'b0;
    case (in_req.operation)
      owq_pkg::OP_PUT: begin
        if (any_hit) begin
          st = owq_pkg::ST_DUP;           // already waiting
        end else if (full) begin
          st = owq_pkg::ST_FULL;          // no room, dropped
        end else begin
          st         = owq_pkg::ST_DONE;
          cnt_after  = count_r + CNT_W'(1);
          ctl.do_put = accept;
        end
      end
      owq_pkg::OP_POP, owq_pkg::OP_REMOVE: begin
        // pop hits the head cell when not empty; remove hits the matching cell
        if (any_hit) begin
          st          = owq_pkg::ST_DONE;
          got         = got_c[QUEUE_DEPTH];
          cnt_after   = count_r - CNT_W'(1);
          ctl.do_take = accept;
        end
      end
      default: begin
        st = owq_pkg::ST_NONE;            // unused code, no effect
      end
    endcase
  end

  assign count_nxt = accept ? cnt_after : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= st;
      out_id_r <= got;
      occ_r    <= cnt_after;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.status      = status_r;
  assign out_res.out_task_id = out_id_r;
  assign out_res.occupancy   = occ_r;

  // identifiers are unique, so at most one cell can match
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one cell matched");

  // held entries stay packed and agree with the count
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_vec) == 32'(count_r)) && (count_r <= CNT_W'(QUEUE_DEPTH)))
    else $error("valid bits disagree with count");

  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (((valid_vec >> 1) & ~valid_vec) == '0))
    else $error("gap in the cell row");

  // a completed put grows the queue by one
  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.operation == owq_pkg::OP_PUT) && (st == owq_pkg::ST_DONE))
    |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("put did not grow the queue");

  // a refused put leaves the row untouched
  a_refused_put: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.operation == owq_pkg::OP_PUT) && (st != owq_pkg::ST_DONE))
    |=> (valid_vec == $past(valid_vec)))
    else $error("refused put changed the queue");

endmodule
